>>> hdl/wpt_pkg.sv
// ----------------------------------------------------------------------------
// wpt_pkg: shared types and constants
// Request and result structures, request codes, status codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wpt_pkg;

	localparam logic [15:0] PROB_ONE  = 16'hFFFF;
	localparam logic [15:0] PROB_HALF = 16'h8000;

	typedef enum logic [1:0] {
		REQ_SPAWN    = 2'd0,
		REQ_COLLAPSE = 2'd1,
		REQ_UPDATE   = 2'd2,
		REQ_QUERY    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_IDX  = 2'd1,
		ST_FULL     = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  entry_index;
		logic        root_spawn;
		logic [15:0] weight;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  new_id;
		logic [15:0] target_probability;
		logic        target_active;
		logic [8:0]  active_count;
	} rsp_t;

	// controller commands to the datapath
	typedef struct packed {
		logic load;      // capture request, start walk at zero
		logic spawn;     // append entry
		logic collapse;  // collapse onto target
		logic wmul;      // weight multiply of target
		logic wsat;      // saturate and store target
		logic sum_step;  // accumulate current entry into total if active
		logic rewind;    // restart walk at zero
		logic scl_start; // start rescale of current entry
		logic scl_store; // store quotient of current entry
		logic next;      // advance entry pointer
		logic finish;    // build result
	} cmd_t;

	typedef struct packed {
		logic full;
		logic bad_idx;
		logic walk_last;
		logic cur_active;
		logic total_zero;
		logic div_done;
	} sts_t;

endpackage

>>> hdl/wpt_div.sv
// ----------------------------------------------------------------------------
// wpt_div: iterative restoring divider
// Divides a 33-bit numerator by a 24-bit denominator, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module wpt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,
	input  logic [23:0] den,
	output logic        done,
	output logic [32:0] quo
);

	logic [24:0] rem_q;
	logic [32:0] quo_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [24:0] trial;

	assign trial = {rem_q[23:0], quo_q[32]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial;
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;

endmodule

>>> hdl/wpt_datapath.sv
// ----------------------------------------------------------------------------
// wpt_datapath: entry store, walk pointer, accumulator and divider
// Holds probabilities, active flags and fill count; executes the
// controller's commands one entry per step.
// ----------------------------------------------------------------------------
module wpt_datapath #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wpt_pkg::req_t      req,
	input  wpt_pkg::cmd_t      cmd,
	output wpt_pkg::sts_t      sts,
	output wpt_pkg::rsp_t      rsp
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [15:0]   prob_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] act_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [7:0]    idx_q;
	logic [1:0]    req_q;
	logic          root_q;
	logic [15:0]   wgt_q;
	logic [31:0]   prod_q;
	logic [23:0]   total_q;
	logic [15:0]   cur_q;
	logic [15:0]   tgt_q;
	logic          rsp_full_q;
	logic          div_start;
	logic          div_done;
	logic [32:0]   div_quo;
	logic [32:0]   num;
	logic [8:0]    nact;
	logic [IW-1:0] ptr_i;
	logic [IW-1:0] idx_i;
	logic [IW-1:0] cnt_i;
	wpt_pkg::rsp_t rsp_d;

	assign ptr_i = ptr_q[IW-1:0];
	assign idx_i = idx_q[IW-1:0];
	assign cnt_i = count_q[IW-1:0];

	always_comb begin
		nact = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			nact = nact + 9'(act_q[i]);
		end
	end

	assign num = 33'({17'd0, cur_q} * 33'(wpt_pkg::PROB_ONE)) + 33'(total_q >> 1);
	assign div_start = cmd.scl_start;

	wpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (total_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		rsp_d = '0;
		rsp_d.active_count = nact;
		if (req_q == wpt_pkg::REQ_SPAWN) begin
			if (rsp_full_q) begin
				rsp_d.status = wpt_pkg::ST_FULL;
			end else begin
				rsp_d.new_id             = 8'(count_q - CW'(1));
				rsp_d.target_probability = root_q ? wpt_pkg::PROB_ONE : wpt_pkg::PROB_HALF;
				rsp_d.target_active      = 1'b1;
			end
		end else if (sts.bad_idx) begin
			rsp_d.status = wpt_pkg::ST_BAD_IDX;
		end else begin
			rsp_d.target_probability = tgt_q;
			rsp_d.target_active      = act_q[idx_i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.load || cmd.rewind) begin
				ptr_q <= '0;
			end else if (cmd.next) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.spawn) begin
				act_q[cnt_i] <= 1'b1;
				count_q      <= count_q + CW'(1);
			end
			if (cmd.collapse) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (i != 32'(idx_q)) begin
						act_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q   <= req.entry_index;
			req_q   <= req.req_type;
			root_q  <= req.root_spawn;
			wgt_q   <= req.weight;
			total_q <= '0;
		end
		cur_q <= prob_mem[ptr_i];
		tgt_q <= prob_mem[idx_i];
		if (cmd.wmul) begin
			prod_q <= 32'(tgt_q) * 32'(wgt_q);
		end
		if (cmd.spawn) begin
			prob_mem[cnt_i] <= root_q ? wpt_pkg::PROB_ONE : wpt_pkg::PROB_HALF;
		end
		if (cmd.collapse) begin
			prob_mem[idx_i] <= wpt_pkg::PROB_ONE;
		end
		if (cmd.wsat) begin
			prob_mem[idx_i] <= (prod_q[31:24] != 8'd0) ? wpt_pkg::PROB_ONE
				: prod_q[23:8];
		end
		if (cmd.sum_step && act_q[ptr_i]) begin
			total_q <= total_q + 24'(cur_q);
		end
		if (cmd.scl_store) begin
			prob_mem[ptr_i] <= (div_quo > 33'(wpt_pkg::PROB_ONE)) ? wpt_pkg::PROB_ONE
				: div_quo[15:0];
		end
		if (cmd.finish) begin
			rsp <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_full_q <= (count_q == CW'(MAX_ENTRIES));
		end
	end

	assign sts.full       = rsp_full_q;
	assign sts.bad_idx    = (9'(idx_q) >= 9'(count_q));
	assign sts.walk_last  = (ptr_q + CW'(1) >= count_q);
	assign sts.cur_active = act_q[ptr_i];
	assign sts.total_zero = (total_q == '0);
	assign sts.div_done   = div_done;

endmodule

>>> hdl/wpt_ctrl.sv
// ----------------------------------------------------------------------------
// wpt_ctrl: request sequencer
// Accepts a request, steps the datapath through it and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module wpt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  wpt_pkg::req_t req,
	output logic          out_valid,
	input  logic          out_stall,
	output wpt_pkg::cmd_t cmd,
	input  wpt_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_RD, S_MUL, S_SAT, S_SUM_RD, S_SUM, S_SCL_RD,
		S_SCL_GO, S_SCL_WAIT, S_TGT_RD, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] rt_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.load = in_valid;
			S_DECODE: begin
				if (rt_q == wpt_pkg::REQ_SPAWN) begin
					cmd.spawn = !sts.full;
				end else if (!sts.bad_idx && rt_q == wpt_pkg::REQ_COLLAPSE) begin
					cmd.collapse = 1'b1;
				end
			end
			S_MUL:      cmd.wmul = 1'b1;
			S_SAT:      cmd.wsat = 1'b1;
			S_SUM: begin
				cmd.sum_step = 1'b1;
				cmd.next     = !sts.walk_last;
				cmd.rewind   = sts.walk_last;
			end
			S_SCL_GO: begin
				cmd.scl_start = sts.cur_active;
				cmd.next      = !sts.cur_active;
			end
			S_SCL_WAIT: begin
				cmd.scl_store = sts.div_done;
				cmd.next      = sts.div_done;
			end
			S_FIN:      cmd.finish = 1'b1;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			rt_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rt_q    <= req.req_type;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (rt_q == wpt_pkg::REQ_UPDATE && !sts.bad_idx) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_TGT_RD;
					end
				end
				S_RD:     state_q <= S_MUL;
				S_MUL:    state_q <= S_SAT;
				S_SAT:    state_q <= S_SUM_RD;
				S_SUM_RD: state_q <= S_SUM;
				S_SUM: begin
					if (sts.walk_last) begin
						state_q <= S_SCL_RD;
					end else begin
						state_q <= S_SUM_RD;
					end
				end
				S_SCL_RD: begin
					if (sts.total_zero) begin
						state_q <= S_TGT_RD;
					end else begin
						state_q <= S_SCL_GO;
					end
				end
				S_SCL_GO: begin
					if (sts.cur_active) begin
						state_q <= S_SCL_WAIT;
					end else begin
						state_q <= sts.walk_last ? S_TGT_RD : S_SCL_RD;
					end
				end
				S_SCL_WAIT: begin
					if (sts.div_done) begin
						state_q <= sts.walk_last ? S_TGT_RD : S_SCL_RD;
					end
				end
				S_TGT_RD: state_q <= S_FIN;
				S_FIN: begin
					out_valid <= 1'b1;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_valid_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == S_OUT))
		else $error("result valid outside output state");
	a_fin_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> out_valid)
		else $error("result not shown after finish");

endmodule

>>> hdl/weighted_probability_table.sv
// ----------------------------------------------------------------------------
// weighted_probability_table: probability table with spawn, collapse,
// weight update and query requests
//
// Input channel in_valid/in_stall carries one request (req struct); output
// channel out_valid/out_stall returns one result per request.
// One request is worked at a time; in_stall is high from acceptance until
// the result has been taken.
// Spawn, collapse, query and a rejected request pass through decode, target
// read and finish before out_valid rises. An update multiplies and saturates
// the target weight, walks the used entries to total the active ones, then
// walks them again to rescale each active entry with the serial divider
// (the second walk is skipped when the active total is zero).
// Reset clears the active flags and fill count; probabilities are written
// by the spawn that brings an entry into use.
// A stalled result holds its value until out_stall falls.
// ----------------------------------------------------------------------------
module weighted_probability_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  wpt_pkg::req_t req,
	output logic          out_valid,
	input  logic          out_stall,
	output wpt_pkg::rsp_t rsp
);

	wpt_pkg::cmd_t cmd;
	wpt_pkg::sts_t sts;

	wpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req       (req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	wpt_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
